FILE: src/pcts_pkg.sv
// Package for the periodic callback tick scheduler.
// Sizes, opcode and status codes, and the divider status struct.
// No dependencies.
`default_nettype none

package pcts_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int TICK_BITS  = 32;
   localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int STEP_BITS  = $clog2(TICK_BITS + 1);

   // input opcodes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_REGISTER = 1'b1;

   // result status codes
   localparam logic [1:0] ST_FIRE   = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // modulo unit status
   typedef struct packed {
      logic busy;
      logic rem_zero;
   } mod_status_type;

endpackage

`default_nettype wire

FILE: src/periodic_callback_tick_scheduler_core.sv
// Periodic callback tick scheduler, top level.
// Register item: one result, registered, in the cycle after the transfer; the next item can be
// taken then unless the output stalls. Tick item: slots rotate past one shared modulo unit,
// each through launch, divide and decide, then a flush state; output stalls hold the sequencer.
// Synchronous active-high reset clears count, pointer and all slots at once.
// Depends on pcts_pkg, pcts_slot_cell, pcts_mod_unit.
`default_nettype none

module periodic_callback_tick_scheduler_core
   import pcts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_period,
   input  wire logic [7:0]  req_handler_tag,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [1:0]  rsp_status,
   output logic      [2:0]  rsp_slot_index,
   output logic      [7:0]  rsp_fired_tag,
   output logic      [31:0] rsp_tick_count,
   output logic             rsp_last
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LAUNCH = 5'b00010,
      S_DIVIDE = 5'b00100,
      S_DECIDE = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [TICK_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0] ptr_ff, ptr_in, ptr_next;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pend_slot_ff, pend_slot_in;
   logic [7:0]           pend_tag_ff, pend_tag_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_slot_ff, rsp_slot_in;
   logic [7:0]           rsp_tag_ff, rsp_tag_in;
   logic [31:0]          rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_xfer, rsp_xfer, out_free, reg_write, rotate, hit;
   logic [31:0]          cell_period [SLOT_COUNT];
   logic [7:0]           cell_tag    [SLOT_COUNT];
   mod_status_type       mod_status;

   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_xfer  = req_valid && !req_stall;
   assign reg_write = req_xfer && (req_opcode == OP_REGISTER) && (req_handler_tag != 8'd0);
   assign ptr_next  = (ptr_ff == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 : ptr_ff + 1'b1;
   assign hit       = (cell_period[0] != 32'd0) && mod_status.rem_zero;

   // ring of slot cells, head cell 0 feeds the modulo unit
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      pcts_slot_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .load_en     (reg_write && (ptr_next == SLOT_BITS'(i))),
         .load_period (req_period),
         .load_tag    (req_handler_tag),
         .shift_en    (rotate),
         .nbr_period  (cell_period[(i + 1) % SLOT_COUNT]),
         .nbr_tag     (cell_tag[(i + 1) % SLOT_COUNT]),
         .period      (cell_period[i]),
         .tag         (cell_tag[i])
      );
   end

   pcts_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_LAUNCH),
      .dividend (count_ff),
      .divisor  (cell_period[0]),
      .status   (mod_status)
   );

   // sequencer and output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      rotate        = 1'b0;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_opcode == OP_REGISTER) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = 32'(count_ff);
                  rsp_last_in  = 1'b1;
                  if (req_handler_tag == 8'd0) begin
                     rsp_status_in = ST_REJECT;
                     rsp_slot_in   = 3'd0;
                     rsp_tag_in    = 8'd0;
                  end else begin
                     ptr_in        = ptr_next;
                     rsp_status_in = ST_ACCEPT;
                     rsp_slot_in   = 3'(ptr_next);
                     rsp_tag_in    = req_handler_tag;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_LAUNCH: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (!mod_status.busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // a new hit pushes the previous one out, which is then not last
            if (!(hit && pend_ff && !out_free)) begin
               if (hit) begin
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FIRE;
                     rsp_slot_in   = 3'(pend_slot_ff);
                     rsp_tag_in    = pend_tag_ff;
                     rsp_count_in  = 32'(count_ff);
                     rsp_last_in   = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = idx_ff;
                  pend_tag_in  = cell_tag[0];
               end
               rotate = 1'b1;
               if (idx_ff == SLOT_BITS'(SLOT_COUNT - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FIRE;
               rsp_slot_in   = 3'(pend_slot_ff);
               rsp_tag_in    = pend_tag_ff;
               rsp_count_in  = 32'(count_ff);
               rsp_last_in   = 1'b1;
               pend_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_slot_ff  <= pend_slot_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_fired_tag  = rsp_tag_ff;
   assign rsp_tick_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

FILE: src/pcts_slot_cell.sv
// One callback slot of the ring: period and handler tag.
// Loads from the register path or takes its neighbor's contents on rotate.
// Depends on pcts_pkg.
`default_nettype none

module pcts_slot_cell
   import pcts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load_en,
   input  wire logic [31:0] load_period,
   input  wire logic [7:0]  load_tag,
   input  wire logic        shift_en,
   input  wire logic [31:0] nbr_period,
   input  wire logic [7:0]  nbr_tag,
   output logic      [31:0] period,
   output logic      [7:0]  tag
);

   logic [31:0] period_ff, period_in;
   logic [7:0]  tag_ff, tag_in;

   // next contents: load wins, then rotate, else hold
   always_comb begin
      period_in = period_ff;
      tag_in    = tag_ff;
      if (load_en) begin
         period_in = load_period;
         tag_in    = load_tag;
      end else if (shift_en) begin
         period_in = nbr_period;
         tag_in    = nbr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         tag_ff    <= '0;
      end else begin
         period_ff <= period_in;
         tag_ff    <= tag_in;
      end
   end

   assign period = period_ff;
   assign tag    = tag_ff;

endmodule

`default_nettype wire

FILE: src/pcts_mod_unit.sv
// Shared restoring modulo unit: one dividend bit per cycle, remainder only.
// Reports busy and whether the remainder is zero.
// Depends on pcts_pkg.
`default_nettype none

module pcts_mod_unit
   import pcts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [TICK_BITS-1:0] dividend,
   input  wire logic [31:0]          divisor,
   output mod_status_type            status
);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [TICK_BITS-1:0] dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic [32:0]          trial;

   // shift in next dividend bit, subtract divisor when it fits
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[TICK_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(TICK_BITS);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = 32'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[31:0];
         end
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign status.busy     = busy_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for periodic_callback_tick_scheduler_core.
// Directed and random register/tick transfers with random idling on both channels.
// Depends on pcts_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
   import pcts_pkg::*;

   localparam int IDLE_PCT     = 28;
   localparam int RANDOM_ITEMS = 180;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // one input transfer
   typedef struct packed {
      logic        opcode;
      logic [31:0] period;
      logic [7:0]  tag;
   } sched_req_type;

   // one result transfer
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [7:0]  tag;
      logic [31:0] count;
      logic        last;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_TICK;
   logic [31:0] req_period = 32'd0;
   logic [7:0]  req_handler_tag = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_slot_index;
   logic [7:0]  rsp_fired_tag;
   logic [31:0] rsp_tick_count;
   logic        rsp_last;

   sched_req_type    pending_reqs [$];
   sched_result_type due_results [$];
   int               fail_count = 0;
   int               items_taken = 0;
   int               cycle_count = 0;
   logic             quiet_window;

   // scheduler state as the block should hold it
   logic [31:0]          sched_ticks = 32'd0;
   logic [31:0]          sched_period [SLOT_COUNT];
   logic [7:0]           sched_tag [SLOT_COUNT];
   logic [SLOT_BITS-1:0] sched_wptr = '0;

   periodic_callback_tick_scheduler_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_period      (req_period),
      .req_handler_tag (req_handler_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_fired_tag   (rsp_fired_tag),
      .rsp_tick_count  (rsp_tick_count),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side for a stretch in the middle of the run
   assign quiet_window = (items_taken >= 90) && (items_taken < 140);

   function automatic logic slot_due(input int i);
      return (sched_period[i] != 32'd0) && ((sched_ticks % sched_period[i]) == 32'd0);
   endfunction

   // expected results of one accepted transfer
   function automatic void schedule_item(input logic op, input logic [31:0] period,
                                         input logic [7:0] tag);
      int last_hit;
      if (op == OP_REGISTER) begin
         if (tag == 8'd0) begin
            // null handler: rejected, pointer stays
            due_results.push_back('{status: ST_REJECT, slot: 3'd0, tag: 8'd0,
                                    count: sched_ticks, last: 1'b1});
         end else begin
            sched_wptr = sched_wptr + 1'b1;
            sched_period[sched_wptr] = period;
            sched_tag[sched_wptr] = tag;
            due_results.push_back('{status: ST_ACCEPT, slot: 3'(sched_wptr), tag: tag,
                                    count: sched_ticks, last: 1'b1});
         end
      end else begin
         sched_ticks = sched_ticks + 32'd1;
         last_hit = -1;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_due(i)) last_hit = i;
         end
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_due(i)) begin
               due_results.push_back('{status: ST_FIRE, slot: 3'(i), tag: sched_tag[i],
                                       count: sched_ticks, last: (i == last_hit)});
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic add_req(input logic op, input logic [31:0] period, input logic [7:0] tag);
      pending_reqs.push_back('{opcode: op, period: period, tag: tag});
   endtask

   // request driver: a stalled transfer holds its payload
   always @(posedge clock) begin
      sched_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
            item = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_opcode <= item.opcode;
            req_period <= item.period;
            req_handler_tag <= item.tag;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on input transfer, check on result transfer, drive rsp_stall
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            schedule_item(req_opcode, req_period, req_handler_tag);
            items_taken <= items_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: status %0d slot %0d tag 0x%0h count %0d",
                      rsp_status, rsp_slot_index, rsp_fired_tag, rsp_tick_count);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("slot_index", 32'(want.slot), 32'(rsp_slot_index));
               check_field("fired_tag", 32'(want.tag), 32'(rsp_fired_tag));
               check_field("tick_count", want.count, rsp_tick_count);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         rsp_stall <= quiet_window ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [31:0] p;
      logic [7:0]  t;
      int          sel;

      for (int i = 0; i < SLOT_COUNT; i++) begin
         sched_period[i] = 32'd0;
         sched_tag[i] = 8'd0;
      end

      // directed: empty tick, null handler, field extremes, ring wrap
      add_req(OP_TICK, 32'd0, 8'd0);
      add_req(OP_REGISTER, 32'd7, 8'd0);
      add_req(OP_REGISTER, 32'd1, 8'hFF);
      add_req(OP_REGISTER, 32'hFFFF_FFFF, 8'h01);
      add_req(OP_REGISTER, 32'd0, 8'h80);
      add_req(OP_REGISTER, 32'd2, 8'h55);
      add_req(OP_REGISTER, 32'd3, 8'hAA);
      add_req(OP_REGISTER, 32'h8000_0000, 8'h7F);
      add_req(OP_REGISTER, 32'd6, 8'h33);
      add_req(OP_REGISTER, 32'd1, 8'hFE);
      add_req(OP_REGISTER, 32'd4, 8'h11);
      for (int i = 0; i < 6; i++) add_req(OP_TICK, 32'hFFFF_FFFF, 8'hFF);
      add_req(OP_REGISTER, 32'hFFFF_FFFF, 8'd0);
      // every slot period 1: a tick fires all slots
      for (int i = 0; i < SLOT_COUNT; i++) add_req(OP_REGISTER, 32'd1, 8'(i + 2));
      add_req(OP_TICK, 32'd0, 8'd0);

      // random: registrations with mostly small periods among ticks
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if ($urandom_range(99) < 32) begin
            sel = $urandom_range(99);
            if (sel < 55) p = $urandom_range(12, 1);
            else if (sel < 68) p = 32'd0;
            else if (sel < 85) p = $urandom();
            else p = 32'd1 << $urandom_range(31);
            t = ($urandom_range(99) < 8) ? 8'd0 : 8'($urandom_range(255, 1));
            add_req(OP_REGISTER, p, t);
         end else begin
            // tick payload fields are don't-care
            add_req(OP_TICK, $urandom(), 8'($urandom_range(255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      // a tick with no firing slot may still be in progress
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: periodic_callback_tick_scheduler_core.f
src/pcts_pkg.sv
src/pcts_slot_cell.sv
src/pcts_mod_unit.sv
src/periodic_callback_tick_scheduler_core.sv
tb/sv/tb_top.sv
